FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL of the frame tracker.
// Both macros sample on clk_i and are switched off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/mfft_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfft_pkg
// Constants, register codes and shared types of the motor feedback frame
// tracker.
// ---------------------------------------------------------------------------
package mfft_pkg;

  // Motor slots and the identifier of the first one
  localparam int NUM_MOTORS  = 8;
  localparam int BASE_ID     = 513;
  localparam int ID_W        = 11;
  localparam int MOTOR_IDX_W = 3;

  // Encoder and turn tracking
  localparam int ENC_W     = 16;
  localparam int TURN_W    = 16;
  localparam int HALF_TURN = 4096;

  // Configuration
  localparam int RATIO_W          = 10;
  localparam int ANGLE_W          = 41;
  localparam int GEAR_RATIO_RESET = 190;
  localparam int CFG_IDX_W        = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET = 1'b1;

  // Serial divider: dividend and quotient share one shift register
  localparam int DIV_BITS  = ANGLE_W;
  localparam int DIVISOR_W = RATIO_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hw/rtl/mfft_frame_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfft_frame_if
// Valid/ready channel carrying one received feedback frame per word.
// ---------------------------------------------------------------------------
interface mfft_frame_if;
  logic                        valid;
  logic                        ready;
  logic [mfft_pkg::ID_W-1:0]   frame_id;
  logic [7:0]                  data_byte0;
  logic [7:0]                  data_byte1;
  logic [7:0]                  data_byte2;
  logic [7:0]                  data_byte3;
  logic [7:0]                  data_byte4;
  logic [7:0]                  data_byte5;
  logic [7:0]                  data_byte6;

  modport source (
    output valid, frame_id, data_byte0, data_byte1, data_byte2, data_byte3,
           data_byte4, data_byte5, data_byte6,
    input  ready
  );

  modport sink (
    input  valid, frame_id, data_byte0, data_byte1, data_byte2, data_byte3,
           data_byte4, data_byte5, data_byte6,
    output ready
  );
endinterface

FILE: hw/rtl/mfft_result_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfft_result_if
// Valid/ready channel carrying one unpacked and tracked result per word.
// ---------------------------------------------------------------------------
interface mfft_result_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    frame_valid;
  logic [mfft_pkg::MOTOR_IDX_W-1:0]        motor_index;
  logic [mfft_pkg::ENC_W-1:0]              encoder_count;
  logic signed [15:0]                      rotor_speed;
  logic signed [15:0]                      measured_current;
  logic [7:0]                              temperature;
  logic signed [mfft_pkg::TURN_W-1:0]      turn_count;
  logic signed [mfft_pkg::ANGLE_W-1:0]     output_angle;

  modport source (
    output valid, frame_valid, motor_index, encoder_count, rotor_speed,
           measured_current, temperature, turn_count, output_angle,
    input  ready
  );

  modport sink (
    input  valid, frame_valid, motor_index, encoder_count, rotor_speed,
           measured_current, temperature, turn_count, output_angle,
    output ready
  );
endinterface

FILE: hw/rtl/mfft_serial_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfft_serial_div
// Bit-serial restoring divider: one quotient bit per cycle, DIV_BITS quotient
// bits per division. Dividend bits shift out at the top while quotient bits
// shift in at the bottom of the same register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mfft_serial_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [mfft_pkg::DIV_BITS-1:0]       dividend_i,
  input  logic [mfft_pkg::DIVISOR_W-1:0]      divisor_i,
  output mfft_pkg::div_stat_t                 stat_o,
  output logic [mfft_pkg::DIV_BITS-1:0]       quotient_o
);

  logic [mfft_pkg::DIV_BITS-1:0]  quo_q, quo_d;
  logic [mfft_pkg::DIVISOR_W-1:0] rem_q, rem_d;
  logic [mfft_pkg::DIVISOR_W-1:0] dvs_q, dvs_d;
  logic [mfft_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;

  logic [mfft_pkg::DIVISOR_W:0]   trial;
  logic [mfft_pkg::DIVISOR_W:0]   trial_sub;
  logic                           fits;

  // Trial subtraction of one step
  assign trial     = {rem_q, quo_q[mfft_pkg::DIV_BITS-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign fits      = (trial >= {1'b0, dvs_q});

  // Step sequencing
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = mfft_pkg::DIV_CNT_W'(mfft_pkg::DIV_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? trial_sub[mfft_pkg::DIVISOR_W-1:0]
                   : trial[mfft_pkg::DIVISOR_W-1:0];
      quo_d = {quo_q[mfft_pkg::DIV_BITS-2:0], fits};
      cnt_d = cnt_q - mfft_pkg::DIV_CNT_W'(1);
      if (cnt_q == mfft_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

  `ASSERT_CLK(a_done_after_busy, done_q |-> $past(busy_q), "done without a division")
  `ASSERT_NEVER(a_done_and_busy, done_q && busy_q, "done while still busy")
  `ASSERT_CLK(a_rem_below_divisor, busy_q |-> (rem_q < dvs_q || dvs_q == '0),
              "partial remainder not reduced")

endmodule

FILE: hw/rtl/motor_feedback_frame_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_feedback_frame_tracker
// Unpacks motor feedback frames, unwraps the encoder into a turn count per
// motor and reports the output shaft angle in Q24.16 degrees.
// ---------------------------------------------------------------------------
// One frame is worked on at a time. A frame for a known motor passes from
// its acceptance to the next acceptance through these steps: take the frame
// and update the turn count; form the magnitude of the rotor position and
// scale it by shift and add; divide by twice the gear ratio in the
// bit-serial divider (41 quotient bits at one a cycle), which then hands
// the quotient back; and apply sign, offset and saturation. A frame with an
// unknown identifier skips the arithmetic and leaves the motor state alone.
// Results wait in an output register, so the next frame is taken while the
// last result is still on offer; only a second finished result waits for
// the first to be taken. The user must write gear ratio and angle offset
// through the plain write port only while idle; the block does not enforce
// this. A gear ratio of zero acts as one. All motor state is zero after
// reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module motor_feedback_frame_tracker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mfft_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [mfft_pkg::ANGLE_W-1:0]           cfg_wdata_i,
  mfft_frame_if.sink                             frame_i,
  mfft_result_if.source                          result_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_ABS,
    ST_MUL5,
    ST_MUL9,
    ST_LOAD,
    ST_DIVIDE,
    ST_SIGN,
    ST_FINISH
  } state_e;

  localparam int AW = mfft_pkg::ANGLE_W;

  // Configuration registers
  logic [mfft_pkg::RATIO_W-1:0] gear_q;
  logic [AW-1:0]                offset_q;

  // Per-motor state
  logic [mfft_pkg::ENC_W-1:0]  last_enc_q [mfft_pkg::NUM_MOTORS];
  logic [mfft_pkg::TURN_W-1:0] turns_q    [mfft_pkg::NUM_MOTORS];

  // Sequencer and working registers
  state_e                          state_q, state_d;
  logic [AW-1:0]                   acc_q, acc_d;
  logic                            neg_q, neg_d;
  logic                            fv_q, fv_d;
  logic [mfft_pkg::MOTOR_IDX_W-1:0] slot_q, slot_d;
  logic [mfft_pkg::ENC_W-1:0]      enc_q, enc_d;
  logic [15:0]                     speed_q, speed_d;
  logic [15:0]                     cur_q, cur_d;
  logic [7:0]                      temp_q, temp_d;
  logic [mfft_pkg::TURN_W-1:0]     tcnt_q, tcnt_d;

  // Output register
  logic                            out_valid_q, out_valid_d;
  logic                            out_fv_q, out_fv_d;
  logic [mfft_pkg::MOTOR_IDX_W-1:0] out_slot_q, out_slot_d;
  logic [mfft_pkg::ENC_W-1:0]      out_enc_q, out_enc_d;
  logic [15:0]                     out_speed_q, out_speed_d;
  logic [15:0]                     out_cur_q, out_cur_d;
  logic [7:0]                      out_temp_q, out_temp_d;
  logic [mfft_pkg::TURN_W-1:0]     out_turns_q, out_turns_d;
  logic [AW-1:0]                   out_angle_q, out_angle_d;

  // Frame decode and turn update
  logic                            frame_ready;
  logic                            frame_accept;
  logic                            res_take;
  logic [mfft_pkg::ID_W:0]         id_off;
  logic                            id_ok;
  logic [mfft_pkg::MOTOR_IDX_W-1:0] slot_in;
  logic [mfft_pkg::ENC_W-1:0]      enc_in;
  logic [mfft_pkg::ENC_W-1:0]      last_sel;
  logic [mfft_pkg::TURN_W-1:0]     turn_sel;
  logic [mfft_pkg::ENC_W:0]        enc_diff;
  logic [mfft_pkg::TURN_W-1:0]     turn_new;
  logic                            state_upd;

  // Arithmetic
  logic [mfft_pkg::RATIO_W-1:0]    ratio_eff;
  logic [AW-1:0]                   dividend;
  logic                            div_start;
  mfft_pkg::div_stat_t             div_stat;
  logic [AW-1:0]                   div_quot;
  logic [AW:0]                     ang_diff;
  logic [AW-1:0]                   ang_sat;

  assign frame_ready   = (state_q == ST_IDLE);
  assign frame_i.ready = frame_ready;
  assign frame_accept  = frame_i.valid && frame_ready;
  assign res_take      = out_valid_q && result_o.ready;

  // Decode the identifier into a motor slot
  assign id_off  = {1'b0, frame_i.frame_id} - (mfft_pkg::ID_W + 1)'(mfft_pkg::BASE_ID);
  assign id_ok   = !id_off[mfft_pkg::ID_W] &&
                   (id_off < (mfft_pkg::ID_W + 1)'(mfft_pkg::NUM_MOTORS));
  assign slot_in = id_off[mfft_pkg::MOTOR_IDX_W-1:0];
  assign enc_in  = {frame_i.data_byte0, frame_i.data_byte1};

  // Compare with the last encoder and step the turn count, saturating
  assign last_sel = last_enc_q[slot_in];
  assign turn_sel = turns_q[slot_in];
  assign enc_diff = {1'b0, enc_in} - {1'b0, last_sel};

  always_comb begin
    turn_new = turn_sel;
    if ($signed(enc_diff) > $signed((mfft_pkg::ENC_W + 1)'(mfft_pkg::HALF_TURN))) begin
      if (turn_sel != {1'b1, {(mfft_pkg::TURN_W-1){1'b0}}}) begin
        turn_new = turn_sel - mfft_pkg::TURN_W'(1);
      end
    end else if ($signed(enc_diff) <
                 -$signed((mfft_pkg::ENC_W + 1)'(mfft_pkg::HALF_TURN))) begin
      if (turn_sel != {1'b0, {(mfft_pkg::TURN_W-1){1'b1}}}) begin
        turn_new = turn_sel + mfft_pkg::TURN_W'(1);
      end
    end
  end

  assign state_upd = frame_accept && id_ok;

  // Hold the per-motor encoder and turn count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mfft_pkg::NUM_MOTORS; i++) begin
        last_enc_q[i] <= '0;
        turns_q[i]    <= '0;
      end
    end else if (state_upd) begin
      last_enc_q[slot_in] <= enc_in;
      turns_q[slot_in]    <= turn_new;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_q   <= mfft_pkg::RATIO_W'(mfft_pkg::GEAR_RATIO_RESET);
      offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mfft_pkg::REG_GEAR_RATIO:   gear_q   <= cfg_wdata_i[mfft_pkg::RATIO_W-1:0];
        mfft_pkg::REG_ANGLE_OFFSET: offset_q <= cfg_wdata_i;
      endcase
    end
  end

  // Dividend is twice the scaled magnitude plus the ratio, for rounding
  assign ratio_eff = (gear_q == '0) ? mfft_pkg::RATIO_W'(1) : gear_q;
  assign dividend  = {acc_q[AW-8:0], 7'b0} + {{(AW - mfft_pkg::RATIO_W){1'b0}}, ratio_eff};
  assign div_start = (state_q == ST_LOAD);

  mfft_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  ({ratio_eff, 1'b0}),
    .stat_o     (div_stat),
    .quotient_o (div_quot)
  );

  // Subtract the offset and clamp to the angle range
  assign ang_diff = {acc_q[AW-1], acc_q} - {offset_q[AW-1], offset_q};
  always_comb begin
    if (ang_diff[AW] != ang_diff[AW-1]) begin
      ang_sat = ang_diff[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      ang_sat = ang_diff[AW-1:0];
    end
  end

  // Sequence one frame through scaling, division and output
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    fv_d        = fv_q;
    slot_d      = slot_q;
    enc_d       = enc_q;
    speed_d     = speed_q;
    cur_d       = cur_q;
    temp_d      = temp_q;
    tcnt_d      = tcnt_q;
    out_valid_d = res_take ? 1'b0 : out_valid_q;
    out_fv_d    = out_fv_q;
    out_slot_d  = out_slot_q;
    out_enc_d   = out_enc_q;
    out_speed_d = out_speed_q;
    out_cur_d   = out_cur_q;
    out_temp_d  = out_temp_q;
    out_turns_d = out_turns_q;
    out_angle_d = out_angle_q;

    unique case (state_q)
      ST_IDLE: begin
        if (frame_accept) begin
          fv_d    = id_ok;
          slot_d  = slot_in;
          enc_d   = enc_in;
          speed_d = {frame_i.data_byte2, frame_i.data_byte3};
          cur_d   = {frame_i.data_byte4, frame_i.data_byte5};
          temp_d  = frame_i.data_byte6;
          tcnt_d  = turn_new;
          state_d = id_ok ? ST_SUM : ST_FINISH;
        end
      end
      ST_SUM: begin
        acc_d   = {{(AW - mfft_pkg::TURN_W - 13){tcnt_q[mfft_pkg::TURN_W-1]}}, tcnt_q, 13'b0}
                + {{(AW - mfft_pkg::ENC_W){1'b0}}, enc_q};
        state_d = ST_ABS;
      end
      ST_ABS: begin
        neg_d   = acc_q[AW-1];
        acc_d   = acc_q[AW-1] ? (~acc_q + AW'(1)) : acc_q;
        state_d = ST_MUL5;
      end
      ST_MUL5: begin
        acc_d   = {acc_q[AW-3:0], 2'b0} + acc_q;
        state_d = ST_MUL9;
      end
      ST_MUL9: begin
        acc_d   = {acc_q[AW-4:0], 3'b0} + acc_q;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          acc_d   = div_quot;
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        acc_d   = neg_q ? (~acc_q + AW'(1)) : acc_q;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_fv_d    = fv_q;
          out_slot_d  = fv_q ? slot_q  : '0;
          out_enc_d   = fv_q ? enc_q   : '0;
          out_speed_d = fv_q ? speed_q : '0;
          out_cur_d   = fv_q ? cur_q   : '0;
          out_temp_d  = fv_q ? temp_q  : '0;
          out_turns_d = fv_q ? tcnt_q  : '0;
          out_angle_d = fv_q ? ang_sat : '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      fv_q        <= 1'b0;
      slot_q      <= '0;
      enc_q       <= '0;
      speed_q     <= '0;
      cur_q       <= '0;
      temp_q      <= '0;
      tcnt_q      <= '0;
      out_valid_q <= 1'b0;
      out_fv_q    <= 1'b0;
      out_slot_q  <= '0;
      out_enc_q   <= '0;
      out_speed_q <= '0;
      out_cur_q   <= '0;
      out_temp_q  <= '0;
      out_turns_q <= '0;
      out_angle_q <= '0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      fv_q        <= fv_d;
      slot_q      <= slot_d;
      enc_q       <= enc_d;
      speed_q     <= speed_d;
      cur_q       <= cur_d;
      temp_q      <= temp_d;
      tcnt_q      <= tcnt_d;
      out_valid_q <= out_valid_d;
      out_fv_q    <= out_fv_d;
      out_slot_q  <= out_slot_d;
      out_enc_q   <= out_enc_d;
      out_speed_q <= out_speed_d;
      out_cur_q   <= out_cur_d;
      out_temp_q  <= out_temp_d;
      out_turns_q <= out_turns_d;
      out_angle_q <= out_angle_d;
    end
  end

  // Drive the result word
  assign result_o.valid            = out_valid_q;
  assign result_o.frame_valid      = out_fv_q;
  assign result_o.motor_index      = out_slot_q;
  assign result_o.encoder_count    = out_enc_q;
  assign result_o.rotor_speed      = $signed(out_speed_q);
  assign result_o.measured_current = $signed(out_cur_q);
  assign result_o.temperature      = out_temp_q;
  assign result_o.turn_count       = $signed(out_turns_q);
  assign result_o.output_angle     = $signed(out_angle_q);

  `ASSERT_NEVER(a_start_while_busy, div_start && div_stat.busy, "divider restarted while busy")
  `ASSERT_CLK(a_divide_tracks_div, (state_q == ST_DIVIDE) |-> (div_stat.busy || div_stat.done),
              "sequencer waits on an idle divider")
  `ASSERT_CLK(a_reject_skips, (frame_accept && !id_ok) |=> (state_q == ST_FINISH && !fv_q),
              "unknown identifier entered the arithmetic")
  `ASSERT_CLK(a_reject_zero, (out_valid_q && !out_fv_q) |-> (out_angle_q == '0 && out_turns_q == '0),
              "rejected frame carries data")

endmodule

FILE: tb/tb_motor_feedback_frame_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_feedback_frame_tracker
// Self-checking bench for the motor feedback frame tracker. A short directed
// run covers identifier edges, the turn wrap thresholds, the first frame
// after reset and field extremes. Phases of random frames then run under
// several gear ratio and offset settings, the extremes among them. Every
// accepted frame passes through a local model of the encoder unwrap and the
// angle scaling, and each result word is checked in order against it.
// ----------------------------------------------------------------------------
module tb_motor_feedback_frame_tracker;
  import mfft_pkg::*;

  localparam int     COUNTS_PER_TURN   = 8192;
  localparam longint Q16_DEG_PER_COUNT = 2880;
  localparam longint ANGLE_HI          = (longint'(1) << (ANGLE_W - 1)) - 1;
  localparam longint ANGLE_LO          = -(longint'(1) << (ANGLE_W - 1));
  localparam int     TURN_HI           = 32767;
  localparam int     TURN_LO           = -32768;
  localparam int     ENC_MAX           = 65535;
  localparam int     ID_MAX            = (1 << ID_W) - 1;
  localparam int     CYCLE_LIMIT       = 1_000_000;
  localparam int     NUM_PHASES        = 8;
  localparam int     PHASE_FRAMES      = 210;
  localparam int     REPORT_LIMIT      = 10;
  localparam int     SETTLE_CYCLES     = 100;

  typedef struct packed {
    logic [ID_W-1:0] frame_id;
    logic [7:0]      data_byte0;
    logic [7:0]      data_byte1;
    logic [7:0]      data_byte2;
    logic [7:0]      data_byte3;
    logic [7:0]      data_byte4;
    logic [7:0]      data_byte5;
    logic [7:0]      data_byte6;
  } frame_t;

  typedef struct packed {
    logic                      frame_valid;
    logic [MOTOR_IDX_W-1:0]    motor_index;
    logic [ENC_W-1:0]          encoder_count;
    logic signed [15:0]        rotor_speed;
    logic signed [15:0]        measured_current;
    logic [7:0]                temperature;
    logic signed [TURN_W-1:0]  turn_count;
    logic signed [ANGLE_W-1:0] output_angle;
  } result_t;

  // Tracks turns per motor, predicts each result word and checks it in order
  class angle_tracker_board;
    result_t            pending_results[$];
    logic [RATIO_W-1:0] gear_ratio;
    longint             angle_offset;
    logic [ENC_W-1:0]   last_enc[NUM_MOTORS];
    shortint            turns[NUM_MOTORS];
    int                 error_count;

    function new();
      gear_ratio   = RATIO_W'(GEAR_RATIO_RESET);
      angle_offset = 0;
      error_count  = 0;
      foreach (last_enc[i]) begin
        last_enc[i] = '0;
        turns[i]    = 0;
      end
    endfunction

    function void set_config(logic [RATIO_W-1:0] gear, logic signed [ANGLE_W-1:0] off);
      gear_ratio   = gear;
      angle_offset = off;
    endfunction

    function logic [ENC_W-1:0] last_encoder(int slot);
      return last_enc[slot];
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Unwrap the encoder into turns and scale to Q24.16 degrees
    function result_t unwrap_angle(frame_t f);
      result_t          r;
      int               slot;
      int               delta;
      int               t;
      longint           ratio;
      longint           num;
      longint           mag;
      longint           q;
      longint           ang;
      logic [ENC_W-1:0] enc;
      r = '0;
      if (f.frame_id < BASE_ID || f.frame_id >= BASE_ID + NUM_MOTORS) return r;
      slot  = int'(f.frame_id) - BASE_ID;
      enc   = {f.data_byte0, f.data_byte1};
      delta = int'(enc) - int'(last_enc[slot]);
      t     = turns[slot];
      if (delta > HALF_TURN) begin
        if (t > TURN_LO) t--;
      end else if (delta < -HALF_TURN) begin
        if (t < TURN_HI) t++;
      end
      turns[slot]    = shortint'(t);
      last_enc[slot] = enc;

      // Round half away from zero; a zero ratio acts as one
      ratio = (gear_ratio == 0) ? longint'(1) : longint'(gear_ratio);
      num   = (longint'(t) * COUNTS_PER_TURN + longint'(enc)) * Q16_DEG_PER_COUNT;
      mag   = (num < 0) ? -num : num;
      q     = (mag * 2 + ratio) / (ratio * 2);
      if (num < 0) q = -q;
      ang = q - angle_offset;
      if (ang > ANGLE_HI) ang = ANGLE_HI;
      if (ang < ANGLE_LO) ang = ANGLE_LO;

      r.frame_valid      = 1'b1;
      r.motor_index      = MOTOR_IDX_W'(slot);
      r.encoder_count    = enc;
      r.rotor_speed      = {f.data_byte2, f.data_byte3};
      r.measured_current = {f.data_byte4, f.data_byte5};
      r.temperature      = f.data_byte6;
      r.turn_count       = t[TURN_W-1:0];
      r.output_angle     = ang[ANGLE_W-1:0];
      return r;
    endfunction

    function void note_frame(frame_t f);
      pending_results.push_back(unwrap_angle(f));
    endfunction

    function string describe(result_t r);
      return $sformatf("valid=%0b motor=%0d enc=%0d speed=%0d current=%0d temp=%0d turns=%0d angle=%0d",
                       r.frame_valid, r.motor_index, r.encoder_count, r.rotor_speed,
                       r.measured_current, r.temperature, r.turn_count, r.output_angle);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: result word with none expected: %s", $realtime, describe(got));
        return;
      end
      want = pending_results.pop_front();
      if (got.frame_valid !== want.frame_valid || got.motor_index !== want.motor_index ||
          got.encoder_count !== want.encoder_count || got.rotor_speed !== want.rotor_speed ||
          got.measured_current !== want.measured_current ||
          got.temperature !== want.temperature || got.turn_count !== want.turn_count ||
          got.output_angle !== want.output_angle) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ANGLE_W-1:0]   cfg_wdata_i;

  mfft_frame_if  frame_ch ();
  mfft_result_if result_ch ();

  angle_tracker_board board;
  result_t            seen;
  int                 cycle_count = 0;
  int                 ready_mode  = 0;
  int                 mode_left   = 0;
  int                 ready_tick  = 0;

  motor_feedback_frame_tracker u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frame_i     (frame_ch),
    .result_o    (result_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop for a hung handshake
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Check each accepted result word, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      seen.frame_valid      = result_ch.frame_valid;
      seen.motor_index      = result_ch.motor_index;
      seen.encoder_count    = result_ch.encoder_count;
      seen.rotor_speed      = result_ch.rotor_speed;
      seen.measured_current = result_ch.measured_current;
      seen.temperature      = result_ch.temperature;
      seen.turn_count       = result_ch.turn_count;
      seen.output_angle     = result_ch.output_angle;
      board.check_result(seen);
    end
    ready_tick <= ready_tick + 1;
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(50, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0:       result_ch.ready <= 1'b1;
        1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
        default: result_ch.ready <= ((ready_tick % 53) < 30);
      endcase
    end
  end

  function automatic frame_t make_frame(int id, int enc, int spd, int cur, int tmp);
    frame_t f;
    f.frame_id                 = ID_W'(id);
    {f.data_byte0, f.data_byte1} = 16'(enc);
    {f.data_byte2, f.data_byte3} = 16'(spd);
    {f.data_byte4, f.data_byte5} = 16'(cur);
    f.data_byte6               = 8'(tmp);
    return f;
  endfunction

  // Mostly frames for known motors, with encoder steps aimed at the wrap
  // thresholds; the rest carry unknown identifiers
  function automatic frame_t random_frame();
    frame_t f;
    int     slot;
    int     enc;
    int     id;
    f.data_byte2 = 8'($urandom);
    f.data_byte3 = 8'($urandom);
    f.data_byte4 = 8'($urandom);
    f.data_byte5 = 8'($urandom);
    f.data_byte6 = 8'($urandom);
    if ($urandom_range(0, 99) < 85) begin
      slot       = $urandom_range(0, NUM_MOTORS - 1);
      f.frame_id = ID_W'(BASE_ID + slot);
      enc        = int'(board.last_encoder(slot));
      case ($urandom_range(0, 9))
        0, 1, 2: enc = $urandom_range(0, ENC_MAX);
        3, 4, 5: enc = enc + int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN;
        6, 7, 8: begin
          case ($urandom_range(0, 3))
            0:       enc = enc - HALF_TURN - 1;
            1:       enc = enc - HALF_TURN;
            2:       enc = enc + HALF_TURN;
            default: enc = enc + HALF_TURN + 1;
          endcase
        end
        default: enc = $urandom_range(0, 1) ? ENC_MAX : 0;
      endcase
      if (enc < 0 || enc > ENC_MAX) enc = $urandom_range(0, ENC_MAX);
      {f.data_byte0, f.data_byte1} = 16'(enc);
    end else begin
      case ($urandom_range(0, 4))
        0:       id = BASE_ID - 1;
        1:       id = BASE_ID + NUM_MOTORS;
        2:       id = 0;
        3:       id = ID_MAX;
        default: begin
          do id = $urandom_range(0, ID_MAX);
          while (id >= BASE_ID && id < BASE_ID + NUM_MOTORS);
        end
      endcase
      f.frame_id   = ID_W'(id);
      f.data_byte0 = 8'($urandom);
      f.data_byte1 = 8'($urandom);
    end
    return f;
  endfunction

  // Offer one frame word and hold it until it is taken
  task automatic send_frame(input frame_t f);
    frame_ch.valid      <= 1'b1;
    frame_ch.frame_id   <= f.frame_id;
    frame_ch.data_byte0 <= f.data_byte0;
    frame_ch.data_byte1 <= f.data_byte1;
    frame_ch.data_byte2 <= f.data_byte2;
    frame_ch.data_byte3 <= f.data_byte3;
    frame_ch.data_byte4 <= f.data_byte4;
    frame_ch.data_byte5 <= f.data_byte5;
    frame_ch.data_byte6 <= f.data_byte6;
    @(posedge clk_i);
    while (!frame_ch.ready) @(posedge clk_i);
    board.note_frame(f);
  endtask

  // Send in bursts of random length with random gaps between them
  task automatic send_random_frames(input int count);
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 40);
    for (int i = 0; i < count; i++) begin
      send_frame(random_frame());
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70) : $urandom_range(0, 4);
        if (gap > 0) begin
          frame_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  // Hold off the sender until every expected word has come back
  task automatic drain_results();
    frame_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_setting(input logic [RATIO_W-1:0] gear,
                               input logic signed [ANGLE_W-1:0] off);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_GEAR_RATIO;
    cfg_wdata_i <= {{(ANGLE_W - RATIO_W){1'b0}}, gear};
    @(posedge clk_i);
    cfg_idx_i   <= REG_ANGLE_OFFSET;
    cfg_wdata_i <= off;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.set_config(gear, off);
  endtask

  task automatic send_directed();
    // First frame after reset on motor 0: big jump from zero drops a turn
    send_frame(make_frame(BASE_ID, ENC_MAX, 16'h7FFF, 16'h8000, 8'hFF));
    send_frame(make_frame(BASE_ID, 0, 16'h8000, 16'h7FFF, 8'h00));
    // Steps of exactly half a turn leave the count alone
    send_frame(make_frame(BASE_ID, HALF_TURN, 16'h0000, 16'hFFFF, 8'h01));
    send_frame(make_frame(BASE_ID, 0, 16'hFFFF, 16'h0000, 8'h80));
    // One count past half a turn wraps both ways; angle goes negative
    send_frame(make_frame(BASE_ID, HALF_TURN + 1, 16'h1234, 16'hEDCB, 8'h7F));
    send_frame(make_frame(BASE_ID, 0, 16'h5555, 16'hAAAA, 8'h55));
    // Every other motor slot
    for (int s = 1; s < NUM_MOTORS - 1; s++)
      send_frame(make_frame(BASE_ID + s, HALF_TURN, s * 16'h1111, -s, 8'(s * 33)));
    send_frame(make_frame(BASE_ID + NUM_MOTORS - 1, HALF_TURN + 1, 16'h8001, 16'h7FFE, 8'hFE));
    // Unknown identifiers at and beyond the motor window
    send_frame(make_frame(0, ENC_MAX, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_frame(make_frame(BASE_ID - 1, ENC_MAX, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_frame(make_frame(BASE_ID + NUM_MOTORS, ENC_MAX, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_frame(make_frame(ID_MAX, ENC_MAX, 16'hFFFF, 16'hFFFF, 8'hFF));
    // Encoder extremes and alternating bit patterns
    send_frame(make_frame(BASE_ID + 2, ENC_MAX, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_frame(make_frame(BASE_ID + 4, 16'h5555, 16'hAAAA, 16'h5555, 8'hAA));
    send_frame(make_frame(BASE_ID + 5, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h55));
  endtask

  initial begin
    logic [RATIO_W-1:0]        gear;
    logic signed [ANGLE_W-1:0] off;
    board = new();

    // Known levels on every input from the start
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= REG_GEAR_RATIO;
    cfg_wdata_i         <= '0;
    frame_ch.valid      <= 1'b0;
    frame_ch.frame_id   <= '0;
    frame_ch.data_byte0 <= '0;
    frame_ch.data_byte1 <= '0;
    frame_ch.data_byte2 <= '0;
    frame_ch.data_byte3 <= '0;
    frame_ch.data_byte4 <= '0;
    frame_ch.data_byte5 <= '0;
    frame_ch.data_byte6 <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_directed();
    drain_results();

    // Random phases, each under its own gear ratio and offset
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          gear = RATIO_W'(1);
          off  = '0;
        end
        1: begin
          gear = RATIO_W'(1023);
          off  = ANGLE_HI[ANGLE_W-1:0];
        end
        2: begin
          gear = '0;
          off  = ANGLE_LO[ANGLE_W-1:0];
        end
        3: begin
          gear = RATIO_W'(1);
          off  = ANGLE_HI[ANGLE_W-1:0];
        end
        4: begin
          gear = RATIO_W'($urandom_range(1, 1023));
          off  = ANGLE_W'({$urandom, $urandom});
        end
        5: begin
          gear = RATIO_W'(GEAR_RATIO_RESET);
          off  = ANGLE_W'(longint'(int'($urandom_range(0, 2097152))) - 1048576);
        end
        6: begin
          gear = RATIO_W'($urandom_range(0, 1023));
          off  = ANGLE_W'({$urandom, $urandom});
        end
        default: begin
          gear = RATIO_W'(512);
          off  = '1;
        end
      endcase
      write_setting(gear, off);
      send_random_frames(PHASE_FRAMES);
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.error_count == 0 && board.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mfft_pkg.sv
hw/rtl/mfft_frame_if.sv
hw/rtl/mfft_result_if.sv
hw/rtl/mfft_serial_div.sv
hw/rtl/motor_feedback_frame_tracker.sv
tb/tb_motor_feedback_frame_tracker.sv
